@@ sv/thin_pkg.sv @@
// ----------------------------------------------------------------------------
// thin_pkg
// shared types, register indexes and the thinning test for one 3x3 window
// ----------------------------------------------------------------------------
package thin_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int COORD_W     = 10;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUBITERATION = 2'd2;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               pixel;
        logic               last;
    } result_t;

    // returns 1 when the center pixel is removed
    function automatic logic thin_deletes(
        input logic p2, input logic p3, input logic p4, input logic p5,
        input logic p6, input logic p7, input logic p8, input logic p9,
        input logic second
    );
        logic [2:0] c_cnt;
        logic [2:0] n1;
        logic [2:0] n2;
        logic [2:0] n_min;
        logic       m;
        c_cnt = 3'(~p2 & (p3 | p4)) + 3'(~p4 & (p5 | p6))
              + 3'(~p6 & (p7 | p8)) + 3'(~p8 & (p9 | p2));
        n1 = 3'(p9 | p2) + 3'(p3 | p4) + 3'(p5 | p6) + 3'(p7 | p8);
        n2 = 3'(p2 | p3) + 3'(p4 | p5) + 3'(p6 | p7) + 3'(p8 | p9);
        n_min = (n1 < n2) ? n1 : n2;
        m = second ? ((p2 | p3 | ~p5) & p4) : ((p6 | p7 | ~p9) & p8);
        return (c_cnt == 3'd1) && (n_min >= 3'd2) && (n_min <= 3'd3) && !m;
    endfunction

endpackage

@@ sv/thinning_subiteration_3x3_top.sv @@
// ----------------------------------------------------------------------------
// thinning_subiteration_3x3_top
// one Guo-Hall thinning subiteration over a raster stream of binary pixels
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one pixel per item in raster order, bit 0 of s_tdata.
//   m_ channel: result items carrying row, column and the new pixel value;
//   m_tlast marks the final result caused by one input pixel.
//   cfg channel: width, height and subiteration select, written while idle.
// order: a border pixel's result passes through the input register and the
//   result queue once its item is accepted; an interior pixel's result is
//   made when the pixel one row down and one column right is accepted.
// throughput: one input item per cycle while the queue has room; one pass through an
//   input register (line store read) and one window evaluation stage feeding a 4-entry
//   result queue. An item causes 0, 1 or 2 results, 1 on average per frame.
// reset: counters, window and queue clear; width and height return to 1024,
//   subiteration to 0. Line stores are not cleared.
// stall: when m_tready is low the queue fills, the window stage holds and
//   s_tready drops once the next item's results no longer fit.
// ----------------------------------------------------------------------------
module thinning_subiteration_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [thin_pkg::S_TDATA_W-1:0]    s_tdata,   // pixel_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [thin_pkg::M_TDATA_W-1:0]    m_tdata,   // out_row, out_col, pixel_out
    output logic                              m_tlast,   // last_of_item
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [thin_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [thin_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import thin_pkg::*;

    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int DW  = (CFG_DATA_W > $clog2(MAX_WIDTH + 1))
                       ? CFG_DATA_W : $clog2(MAX_WIDTH + 1);
    localparam int DH  = (CFG_DATA_W > $clog2(MAX_HEIGHT + 1))
                       ? CFG_DATA_W : $clog2(MAX_HEIGHT + 1);
    localparam logic [DW-1:0] MAX_W = DW'(MAX_WIDTH);
    localparam logic [DH-1:0] MAX_H = DH'(MAX_HEIGHT);

    // configuration
    logic [CFG_DATA_W-1:0] width_cfg_reg;
    logic [CFG_DATA_W-1:0] height_cfg_reg;
    logic                  subiter_reg;

    // position counters and window
    logic [CLW-1:0] col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [5:0]     window_reg;

    // line stores
    logic mem_prev  [MAX_WIDTH];
    logic mem_prev2 [MAX_WIDTH];
    logic q_prev_reg;
    logic q_prev2_reg;

    // window stage
    logic           s1_valid_reg;
    logic           s1_px_reg;
    logic [CLW-1:0] s1_c_reg;
    logic [RW-1:0]  s1_r_reg;
    logic           s1_int_reg;
    logic           s1_brd_reg;

    // result queue
    result_t                fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   head_reg, tail_reg;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;

    logic [DW-1:0]  w_eff;
    logic [DH-1:0]  h_eff;
    logic [DW-1:0]  col_ext, c_ext, c_inc;
    logic [DH-1:0]  row_inc, r_ext, r_inc;
    logic [CLW-1:0] c0;
    logic [RW-1:0]  r0;
    logic           int0, brd0;
    logic           s_acc, s1_adv, pop, fwd, del, px0;
    logic [1:0]     n_res;
    logic [OUT_CNT_W:0] fill_after;
    result_t        res_int, res_brd, push0;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = DW'(1);
        end else if (DW'(width_cfg_reg) > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = DW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = DH'(1);
        end else if (DH'(height_cfg_reg) > MAX_H) begin
            h_eff = MAX_H;
        end else begin
            h_eff = DH'(height_cfg_reg);
        end

        // position of the arriving pixel
        col_ext = DW'(col_reg);
        if (col_ext >= w_eff) begin
            c_ext   = '0;
            row_inc = DH'(row_reg) + DH'(1);
        end else begin
            c_ext   = col_ext;
            row_inc = DH'(row_reg);
        end
        r_ext = (row_inc >= h_eff) ? '0 : row_inc;
        c0    = c_ext[CLW-1:0];
        r0    = r_ext[RW-1:0];
        px0   = s_tdata[0];

        int0 = (r_ext >= DH'(2)) && (c_ext >= DW'(2));
        brd0 = (r_ext == '0) || (c_ext == '0) || (r_ext == h_eff - DH'(1))
            || (c_ext == w_eff - DW'(1));

        // position of the following pixel
        c_inc = c_ext + DW'(1);
        r_inc = r_ext + DH'(1);
        if (c_inc >= w_eff) begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
        end else begin
            col_next = c_inc[CLW-1:0];
            row_next = r0;
        end
    end

    // window evaluation
    always_comb begin
        del = thin_deletes(window_reg[0], q_prev2_reg, q_prev_reg, s1_px_reg,
                           window_reg[2], window_reg[5], window_reg[4],
                           window_reg[3], subiter_reg);
        res_int.row   = COORD_W'(s1_r_reg - RW'(1));
        res_int.col   = COORD_W'(s1_c_reg - CLW'(1));
        res_int.pixel = window_reg[1] & ~del;
        res_int.last  = ~s1_brd_reg;
        res_brd.row   = COORD_W'(s1_r_reg);
        res_brd.col   = COORD_W'(s1_c_reg);
        res_brd.pixel = s1_px_reg;
        res_brd.last  = 1'b1;
        push0 = s1_int_reg ? res_int : res_brd;
        n_res = {1'b0, s1_int_reg} + {1'b0, s1_brd_reg};
    end

    assign pop        = m_tvalid & m_tready;
    assign fill_after = (OUT_CNT_W + 1)'(count_reg) + (OUT_CNT_W + 1)'(n_res)
                      - (OUT_CNT_W + 1)'(pop);
    assign s1_adv     = s1_valid_reg && (fill_after <= (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign s_tready   = !s1_valid_reg || s1_adv;
    assign s_acc      = s_tvalid && s_tready;
    assign fwd        = s1_adv && (s1_c_reg == c0);
    assign count_next = count_reg + (s1_adv ? OUT_CNT_W'(n_res) : '0)
                      - OUT_CNT_W'(pop);

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {3'b000, fifo_reg[head_reg].pixel, fifo_reg[head_reg].col,
                       fifo_reg[head_reg].row};
    assign m_tlast  = fifo_reg[head_reg].last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= IMAGE_WIDTH_RST;
            height_cfg_reg <= IMAGE_HEIGHT_RST;
            subiter_reg    <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            window_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata;
                    REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata;
                    REG_SUBITERATION: subiter_reg    <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_adv) begin
                window_reg <= {window_reg[2:0], s1_px_reg, q_prev_reg, q_prev2_reg};
                tail_reg   <= tail_reg + OUT_PTR_W'(n_res);
            end
            if (s_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (pop) begin
                head_reg <= head_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // line stores with bypass of the column being written
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            mem_prev[s1_c_reg]  <= s1_px_reg;
            mem_prev2[s1_c_reg] <= q_prev_reg;
        end
        if (s_acc) begin
            q_prev_reg  <= fwd ? s1_px_reg  : mem_prev[c0];
            q_prev2_reg <= fwd ? q_prev_reg : mem_prev2[c0];
            s1_px_reg   <= px0;
            s1_c_reg    <= c0;
            s1_r_reg    <= r0;
            s1_int_reg  <= int0;
            s1_brd_reg  <= brd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            if (n_res != 2'd0) begin
                fifo_reg[tail_reg] <= push0;
            end
            if (n_res == 2'd2) begin
                fifo_reg[tail_reg + OUT_PTR_W'(1)] <= res_brd;
            end
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue over capacity");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_c_reg)
            && $stable(s1_r_reg) && $stable(window_reg))
        else $error("stalled window stage changed");

    a_interior_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_int_reg |-> (s1_c_reg >= CLW'(2)) && (s1_r_reg >= RW'(2)))
        else $error("interior result at border position");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !s1_adv |=> count_reg == $past(count_reg) - OUT_CNT_W'(1))
        else $error("queue count mismatch on pop");

endmodule

@@ tb/thinning_subiteration_3x3_top_tb.sv @@
// ----------------------------------------------------------------------------
// thinning_subiteration_3x3_top_tb
// self-checking bench for one Guo-Hall thinning subiteration on a pixel stream
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order while a predictor in the bench keeps its
// own line stores, 3x3 window and position counters and queues the results
// each accepted pixel should release. Every result item is checked field by
// field against the oldest queued result. Directed tests cover the reset
// geometry, counters left past a shrunken width or height, tiny and oversized
// geometry and windows that are thinned by only one of the subiterations.
// Random frames of varied size, density and subiteration follow, first with
// the sender idling lightly and the receiver heavily, then the reverse, then
// with no idling at all.
// ----------------------------------------------------------------------------
module thinning_subiteration_3x3_top_tb;
    import thin_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 250;

    // 3x3 frames in raster order, first pixel in the msb
    localparam logic [8:0] CORNER_NORTH_EAST = 9'b111_011_000;
    localparam logic [8:0] CORNER_SOUTH_WEST = 9'b000_110_111;
    localparam logic [8:0] SOLID_BLOCK       = 9'b111_111_111;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;     // pixel_in
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // out_row, out_col, pixel_out
    logic                   m_tlast;            // last_of_item
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int send_idle_pct = 0;
    int take_stall_pct = 0;
    int bad_results = 0;
    int quiet_cycles = 0;

    // predictor state
    logic [CFG_DATA_W-1:0] pred_width = IMAGE_WIDTH_RST;
    logic [CFG_DATA_W-1:0] pred_height = IMAGE_HEIGHT_RST;
    bit                    pred_second = 1'b0;
    int                    next_row = 0;
    int                    next_col = 0;
    bit                    row_above [MAX_DIM];
    bit                    row_above2 [MAX_DIM];
    bit [5:0]              window_cols = '0;
    result_t               thinned_pixels_due [$];

    result_t seen_result;
    result_t want_result;

    thinning_subiteration_3x3_top #(
        .MAX_WIDTH (MAX_DIM),
        .MAX_HEIGHT(MAX_DIM)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= take_stall_pct);
    end

    function automatic int clamp_dim(input int value, input int limit);
        if (value < 1) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    // compass neighbors of the center pixel
    function automatic bit removes_center(
        input bit nn, input bit ne, input bit ee, input bit se,
        input bit ss, input bit sw, input bit ww, input bit nw,
        input bit second
    );
        int crossings;
        int pairs_a;
        int pairs_b;
        int fewest;
        bit guard;
        crossings = int'(!nn && (ne || ee)) + int'(!ee && (se || ss))
                  + int'(!ss && (sw || ww)) + int'(!ww && (nw || nn));
        pairs_a = int'(nw || nn) + int'(ne || ee) + int'(se || ss) + int'(sw || ww);
        pairs_b = int'(nn || ne) + int'(ee || se) + int'(ss || sw) + int'(ww || nw);
        fewest = (pairs_a < pairs_b) ? pairs_a : pairs_b;
        guard = second ? ((nn || ne || !se) && ee) : ((ss || sw || !nw) && ww);
        return (crossings == 1) && (fewest >= 2) && (fewest <= 3) && !guard;
    endfunction

    task automatic predict_thinned_pixels(input bit px);
        int      w;
        int      h;
        int      r;
        int      c;
        int      n;
        bit      top;
        bit      mid;
        result_t outs [2];
        w = clamp_dim(int'(pred_width), MAX_DIM);
        h = clamp_dim(int'(pred_height), MAX_DIM);
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h) next_row = 0;
        r = next_row;
        c = next_col;
        n = 0;
        top = row_above2[c];
        mid = row_above[c];
        if (r >= 2 && c >= 2) begin
            outs[n].row   = COORD_W'(r - 1);
            outs[n].col   = COORD_W'(c - 1);
            outs[n].pixel = window_cols[1] & !removes_center(window_cols[0], top, mid, px,
                window_cols[2], window_cols[5], window_cols[4], window_cols[3], pred_second);
            outs[n].last  = 1'b0;
            n++;
        end
        if (r == 0 || c == 0 || r == h - 1 || c == w - 1) begin
            outs[n].row   = COORD_W'(r);
            outs[n].col   = COORD_W'(c);
            outs[n].pixel = px;
            outs[n].last  = 1'b0;
            n++;
        end
        if (n > 0) outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) thinned_pixels_due.push_back(outs[i]);
        row_above2[c] = mid;
        row_above[c] = px;
        window_cols = {window_cols[2:0], px, mid, top};
        next_col = c + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = r + 1;
            if (next_row >= h) next_row = 0;
        end
    endtask

    task automatic send_pixel(input bit px);
        logic [S_TDATA_W-1:0] noise;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        noise = S_TDATA_W'($urandom);
        s_tvalid <= 1'b1;
        s_tdata <= {noise[S_TDATA_W-1:1], px};
        do @(posedge aclk); while (!s_tready);
        predict_thinned_pixels(px);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (thinned_pixels_due.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:  pred_width = CFG_DATA_W'(value);
            REG_IMAGE_HEIGHT: pred_height = CFG_DATA_W'(value);
            REG_SUBITERATION: pred_second = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // an item may still be in flight after the last result, so wait a bit more
    task automatic settle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_geometry(input int w, input int h, input bit second);
        settle();
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
        cfg_write(REG_SUBITERATION, int'(second));
    endtask

    task automatic send_frame_3x3(input logic [8:0] pattern);
        for (int i = 8; i >= 0; i--) send_pixel(pattern[i]);
    endtask

    task automatic test_reset_geometry_and_column_wrap();
        // first row of a default 1024 wide frame, then shrink width mid-row
        for (int i = 0; i < 5; i++) send_pixel(i[0]);
        set_geometry(4, 3, 1'b0);
        for (int i = 0; i < 8; i++) send_pixel(1'b1);
    endtask

    task automatic test_row_wrap_on_height_shrink();
        set_geometry(3, 5, 1'b1);
        for (int i = 0; i < 6; i++) send_pixel(!i[0]);
        settle();
        cfg_write(REG_IMAGE_HEIGHT, 2);
        for (int i = 0; i < 6; i++) send_pixel(i[1]);
    endtask

    task automatic test_tiny_geometry();
        set_geometry(0, 0, 1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        set_geometry(2, 1, 1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        set_geometry(1, 2, 1'b0);
        send_pixel(1'b1);
        send_pixel(1'b1);
    endtask

    task automatic test_window_patterns();
        for (int sub = 0; sub < 2; sub++) begin
            set_geometry(3, 3, sub[0]);
            send_frame_3x3(CORNER_NORTH_EAST);
            send_frame_3x3(CORNER_SOUTH_WEST);
            send_frame_3x3(SOLID_BLOCK);
            send_frame_3x3('0);
        end
    endtask

    task automatic test_oversized_width();
        set_geometry(2047, 1, 1'b0);
        for (int i = 0; i < MAX_DIM + 4; i++) send_pixel($urandom_range(1));
    endtask

    task automatic test_oversized_height();
        set_geometry(3, 2047, 1'b1);
        for (int i = 0; i < 3 * 8; i++) send_pixel($urandom_range(99) < 70);
    endtask

    task automatic test_random_frames(input int item_goal);
        int sent;
        int w;
        int h;
        int density;
        sent = 0;
        while (sent < item_goal) begin
            case ($urandom_range(3))
                0: w = 3;
                1: w = $urandom_range(3, 24);
                default: w = $urandom_range(4, 10);
            endcase
            h = ($urandom_range(3) == 0) ? 3 : $urandom_range(3, 8);
            set_geometry(w, h, $urandom_range(1));
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(2))
                    0: density = 15;
                    1: density = 50;
                    default: density = 85;
                endcase
                for (int k = 0; k < w * h; k++) begin
                    if ($urandom_range(149) == 0) wait_results_drained();
                    send_pixel($urandom_range(99) < density);
                end
                sent += w * h;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.row   = m_tdata[COORD_W-1:0];
            seen_result.col   = m_tdata[2*COORD_W-1:COORD_W];
            seen_result.pixel = m_tdata[2*COORD_W];
            seen_result.last  = m_tlast;
            if (thinned_pixels_due.size() == 0) begin
                bad_results++;
                if (bad_results <= REPORT_LIMIT)
                    $display("unexpected result: row %0d col %0d pixel %0d last %0d",
                             seen_result.row, seen_result.col,
                             seen_result.pixel, seen_result.last);
            end else begin
                want_result = thinned_pixels_due.pop_front();
                if (seen_result.row != want_result.row || seen_result.col != want_result.col ||
                    seen_result.pixel != want_result.pixel ||
                    seen_result.last != want_result.last) begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT)
                        $display("bad result: expected row %0d col %0d pixel %0d last %0d, got row %0d col %0d pixel %0d last %0d",
                                 want_result.row, want_result.col, want_result.pixel,
                                 want_result.last, seen_result.row, seen_result.col,
                                 seen_result.pixel, seen_result.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 11;
        take_stall_pct = 50;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_geometry_and_column_wrap();
        test_row_wrap_on_height_shrink();
        test_tiny_geometry();
        test_window_patterns();
        test_oversized_width();
        test_oversized_height();
        test_random_frames(RANDOM_ITEMS);

        settle();
        send_idle_pct = 50;
        take_stall_pct = 11;
        test_random_frames(RANDOM_ITEMS);

        settle();
        send_idle_pct = 0;
        take_stall_pct = 0;
        test_random_frames(RANDOM_ITEMS);

        wait_results_drained();
        repeat (20) @(negedge aclk);
        if (thinned_pixels_due.size() != 0) begin
            bad_results++;
            $display("%0d expected results never arrived", thinned_pixels_due.size());
        end
        if (bad_results == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
